// File: hw/rtl/tlfm_pkg.sv
// ----------------------------------------------------------------------------
// tlfm_pkg
// Types, codes and helpers shared by the tile light map modules.
// ----------------------------------------------------------------------------
package tlfm_pkg;

    // fixed field widths
    localparam int COORD_W    = 8;
    localparam int WALK_W     = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH = 1'd1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_OFFGRID = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RES_PLAIN = 2'd0,
        RES_ADD   = 2'd1,
        RES_QUERY = 2'd2
    } t_res_sel;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } t_dir;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [13:0] pos_x;
        logic [13:0] pos_y;
        logic [15:0] brightness;
        logic [15:0] falloff;
        logic [7:0]  hue_red;
        logic [7:0]  hue_green;
        logic [7:0]  hue_blue;
        logic [15:0] light_id;
    } t_in_item;

    typedef struct packed {
        logic [15:0] new_id;
        logic [1:0]  status;
        logic [7:0]  level;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       y;
        logic signed [WALK_W-1:0] b;
        logic signed [WALK_W-1:0] f;
    } t_walk_item;

    typedef struct packed {
        logic [15:0] id;
        logic [13:0] px;
        logic [13:0] py;
        logic [15:0] b;
        logic [15:0] f;
        logic [23:0] hue;
    } t_light_entry;

    // controller to datapath
    typedef struct packed {
        logic     cap_in;
        logic     clr_rst;
        logic     clr_inc;
        logic     clr_cells;
        logic     clr_visit;
        logic     slot_rst;
        logic     slot_inc;
        logic     tbl_wr;
        logic     tbl_rd;
        logic     valid_set;
        logic     valid_clr;
        logic     ld_src_in;
        logic     ld_src_tbl;
        logic     dir_rst;
        logic     dir_step;
        logic     walk_init;
        logic     q_rd;
        logic     item_ld;
        logic     deposit;
        logic     nb_rst;
        logic     nb_rd;
        logic     nb_push;
        logic     nb_inc;
        logic     head_inc;
        logic     qry_rd;
        logic     qry_mul;
        logic     res_ld;
        t_res_sel res_sel;
        t_status  res_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       origin_on;
        logic       place_on;
        logic       clr_last;
        logic       slot_last;
        logic       slot_free;
        logic       id_match;
        logic       dir_last;
        logic       spread;
        logic       nb_last;
        logic       nb_free;
        logic       walk_last;
        logic       out_busy;
    } t_stat;

    // floor(p / 255) for p below 65280
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

// File: hw/rtl/tile_light_flood_map.sv
// ----------------------------------------------------------------------------
// tile_light_flood_map
// Tile light map with breadth-first light flooding, add, remove and query.
// ----------------------------------------------------------------------------
// One item is worked at a time. After reset a clearing pass over the
// MAX_WIDTH*MAX_DEPTH cells zeroes the grid before the first item is taken.
// A query reads one cell; an off-grid or unknown request ends in a status.
// An add or remove scans the light table, computes the four origin falloffs,
// sweeps the visited map, then walks the lit cells, and each cell that spreads
// checks its four neighbors; a remove of a light stored off the grid stops
// after the scan. The registered reads of the cell, visited and queue memories
// split each cell visit into read and work states. A finished result waits in
// an output register while the next item is taken.
module tile_light_flood_map #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_DEPTH  = 64,
    parameter int MAX_LIGHTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  tlfm_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output tlfm_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tlfm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tlfm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tlfm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    tlfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tlfm_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_DEPTH  (MAX_DEPTH),
        .MAX_LIGHTS (MAX_LIGHTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hw/rtl/tlfm_ram.sv
// ----------------------------------------------------------------------------
// tlfm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tlfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/tlfm_ctrl.sv
// ----------------------------------------------------------------------------
// tlfm_ctrl
// Sequencer for the tile light map: decode, slot scan, flood walk, query.
// ----------------------------------------------------------------------------
module tlfm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tlfm_pkg::t_stat i_stat,
    output tlfm_pkg::t_cmd  o_cmd
);
    import tlfm_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DEC, S_ADD_SCAN, S_ADD_WR, S_RM_RD, S_RM_CMP,
        S_DIR, S_VCLR, S_WINIT, S_WQRD, S_WCRD, S_WDEP, S_NRD, S_NCHK,
        S_WNEXT, S_QRY_RD, S_QRY_MUL, S_RES
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    t_cmd    cmd;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        cmd      = '0;
        cmd.res_status = r_status;
        cmd.res_sel    = RES_PLAIN;
        case (r_state)
            S_CLR: begin
                cmd.clr_cells = 1'b1;
                cmd.clr_inc   = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap_in = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_status = ST_OK;
                case (i_stat.op)
                    OP_ADD: begin
                        if (!i_stat.origin_on) begin
                            n_status = ST_OFFGRID;
                            n_state  = S_RES;
                        end else begin
                            cmd.slot_rst = 1'b1;
                            n_state      = S_ADD_SCAN;
                        end
                    end
                    OP_REMOVE: begin
                        cmd.slot_rst = 1'b1;
                        n_state      = S_RM_RD;
                    end
                    OP_QUERY: begin
                        if (!i_stat.origin_on) begin
                            n_status = ST_OFFGRID;
                            n_state  = S_RES;
                        end else begin
                            n_state = S_QRY_RD;
                        end
                    end
                    default: n_state = S_RES;
                endcase
            end
            S_ADD_SCAN: begin
                if (i_stat.slot_free) begin
                    n_state = S_ADD_WR;
                end else if (i_stat.slot_last) begin
                    n_status = ST_FULL;
                    n_state  = S_RES;
                end else begin
                    cmd.slot_inc = 1'b1;
                end
            end
            S_ADD_WR: begin
                cmd.tbl_wr    = 1'b1;
                cmd.valid_set = 1'b1;
                cmd.ld_src_in = 1'b1;
                cmd.dir_rst   = 1'b1;
                n_state       = S_DIR;
            end
            S_RM_RD: begin
                cmd.tbl_rd = 1'b1;
                n_state    = S_RM_CMP;
            end
            S_RM_CMP: begin
                if (i_stat.id_match) begin
                    cmd.ld_src_tbl = 1'b1;
                    cmd.valid_clr  = 1'b1;
                    cmd.dir_rst    = 1'b1;
                    n_state        = i_stat.place_on ? S_DIR : S_RES;
                end else if (i_stat.slot_last) begin
                    n_status = ST_UNKNOWN;
                    n_state  = S_RES;
                end else begin
                    cmd.slot_inc = 1'b1;
                    n_state      = S_RM_RD;
                end
            end
            // directional falloffs, one multiply a cycle
            S_DIR: begin
                cmd.dir_step = 1'b1;
                cmd.clr_rst  = 1'b1;
                if (i_stat.dir_last) n_state = S_VCLR;
            end
            S_VCLR: begin
                cmd.clr_visit = 1'b1;
                cmd.clr_inc   = 1'b1;
                if (i_stat.clr_last) n_state = S_WINIT;
            end
            S_WINIT: begin
                cmd.walk_init = 1'b1;
                n_state       = S_WQRD;
            end
            S_WQRD: begin
                cmd.q_rd = 1'b1;
                n_state  = S_WCRD;
            end
            S_WCRD: begin
                cmd.item_ld = 1'b1;
                n_state     = S_WDEP;
            end
            S_WDEP: begin
                cmd.deposit = 1'b1;
                cmd.nb_rst  = 1'b1;
                n_state     = i_stat.spread ? S_NRD : S_WNEXT;
            end
            S_NRD: begin
                cmd.nb_rd = 1'b1;
                n_state   = S_NCHK;
            end
            S_NCHK: begin
                cmd.nb_push = i_stat.nb_free;
                cmd.nb_inc  = 1'b1;
                n_state     = i_stat.nb_last ? S_WNEXT : S_NRD;
            end
            S_WNEXT: begin
                cmd.head_inc = 1'b1;
                n_state      = i_stat.walk_last ? S_RES : S_WQRD;
            end
            S_QRY_RD: begin
                cmd.qry_rd = 1'b1;
                n_state    = S_QRY_MUL;
            end
            S_QRY_MUL: begin
                cmd.qry_mul = 1'b1;
                n_state     = S_RES;
            end
            S_RES: begin
                if (r_status == ST_OK && i_stat.op == OP_ADD) begin
                    cmd.res_sel = RES_ADD;
                end else if (r_status == ST_OK && i_stat.op == OP_QUERY) begin
                    cmd.res_sel = RES_QUERY;
                end
                if (!i_stat.out_busy) begin
                    cmd.res_ld = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered status code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: hw/rtl/tlfm_dp.sv
// ----------------------------------------------------------------------------
// tlfm_dp
// Datapath: grid memories, walk queue, light table, arithmetic, result register.
// ----------------------------------------------------------------------------
module tlfm_dp #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_DEPTH  = 64,
    parameter int MAX_LIGHTS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [tlfm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tlfm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  tlfm_pkg::t_in_item                  i_in_data,
    input  tlfm_pkg::t_cmd                      i_cmd,
    output tlfm_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tlfm_pkg::t_out_item                 o_out_data
);
    import tlfm_pkg::*;

    localparam int CELLS = MAX_WIDTH * MAX_DEPTH;
    localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SW    = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int TW    = CW + 1;
    localparam int QW    = $bits(t_walk_item);
    localparam int LW    = $bits(t_light_entry);

    function automatic logic [CW-1:0] cell_idx(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y);
        logic [17:0] t;
        t = 18'(y) * 18'(MAX_WIDTH) + 18'(x);
        return t[CW-1:0];
    endfunction

    function automatic logic [WALK_W-1:0] mag(input logic signed [WALK_W-1:0] v);
        return v[WALK_W-1] ? WALK_W'(-v) : WALK_W'(v);
    endfunction

    // configuration
    logic [CFG_DATA_W-1:0] r_gw, r_gd;
    logic [8:0]            uw, ud;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= 7'd64;
            r_gd <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH: r_gw <= i_cfg_data;
                CFG_GRID_DEPTH: r_gd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign uw = ({2'b0, r_gw} > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {2'b0, r_gw};
    assign ud = ({2'b0, r_gd} > 9'(MAX_DEPTH)) ? 9'(MAX_DEPTH) : {2'b0, r_gd};

    // registers
    t_in_item                  r_in;
    logic [CW-1:0]             r_clr;
    logic [SW-1:0]             r_slot;
    logic [MAX_LIGHTS-1:0]     r_valid;
    logic [15:0]               r_next_id, r_new_id;
    logic [13:0]               r_wpx, r_wpy;
    logic [15:0]               r_wb, r_wf;
    logic [23:0]               r_whue;
    logic                      r_wneg;
    logic [1:0]                r_dk, r_nb;
    logic signed [WALK_W-1:0]  r_dir [4];
    logic [TW-1:0]             r_head, r_tail;
    t_walk_item                r_item;
    logic                      r_q_big;
    logic [7:0]                r_q_lv;
    logic [15:0]               r_qp_r, r_qp_g, r_qp_b;
    logic                      r_out_valid;
    t_out_item                 r_out;

    // memory ports
    logic              lvl_we, col_we, vis_we, q_we, cell_re, vis_re;
    logic [CW-1:0]     lvl_waddr, cell_raddr, vis_waddr, vis_raddr, q_waddr;
    logic [15:0]       lvl_wdata, lvl_rdata;
    logic [23:0]       col_wdata, col_rdata;
    logic              vis_wdata, vis_rdata;
    t_walk_item        q_wdata, q_rdata;
    t_light_entry      tbl_wdata, tbl_rdata;

    // walk arithmetic
    logic signed [WALK_W-1:0] f0, b0, step;
    logic [8:0]               dmul;
    logic [24:0]              dprod;
    logic [15:0]              new_lv;
    logic [WALK_W-1:0]        dm;
    logic [18:0]              dm_up;
    logic [16:0]              dsum;
    logic [COORD_W-1:0]       nx, ny, ox, oy;
    logic                     nb_ok;
    t_walk_item               child, origin;

    assign ox = COORD_W'(r_wpx[13:8]);
    assign oy = COORD_W'(r_wpy[13:8]);
    assign b0 = r_wneg ? -$signed({2'b0, r_wb}) : $signed({2'b0, r_wb});
    assign f0 = r_wneg ? -$signed({2'b0, r_wf}) : $signed({2'b0, r_wf});

    // falloff scale for the origin, by direction
    always_comb begin
        case (r_dk)
            DIR_RIGHT: dmul = 9'd384 - 9'(r_wpx[7:0]);
            DIR_DOWN:  dmul = 9'd384 - 9'(r_wpy[7:0]);
            DIR_LEFT:  dmul = 9'd128 + 9'(r_wpx[7:0]);
            default:   dmul = 9'd128 + 9'(r_wpy[7:0]);
        endcase
        dprod = 25'(r_wf) * 25'(dmul);
    end

    // deposit into the current cell
    always_comb begin
        dm     = mag(r_item.b);
        dm_up  = 19'(dm) + 19'd255;
        dsum   = 17'(lvl_rdata) + 17'(r_item.b[16:8]);
        new_lv = lvl_rdata;
        if (r_item.b[WALK_W-1]) begin
            if (24'(dm) >= {lvl_rdata, 8'b0}) new_lv = 16'd0;
            else new_lv = lvl_rdata - 16'(dm_up[18:8]);
        end else begin
            new_lv = dsum[16] ? 16'hFFFF : dsum[15:0];
        end
    end

    // neighbor of the current cell
    always_comb begin
        nx    = r_item.x;
        ny    = r_item.y;
        nb_ok = 1'b0;
        case (r_nb)
            DIR_RIGHT: begin
                nx    = r_item.x + 1'b1;
                nb_ok = (9'(r_item.x) + 9'd1) < uw;
            end
            DIR_DOWN: begin
                ny    = r_item.y + 1'b1;
                nb_ok = (9'(r_item.y) + 9'd1) < ud;
            end
            DIR_LEFT: begin
                nx    = r_item.x - 1'b1;
                nb_ok = (r_item.x != '0);
            end
            default: begin
                ny    = r_item.y - 1'b1;
                nb_ok = (r_item.y != '0);
            end
        endcase
        step    = (r_head == '0) ? r_dir[r_nb] : f0;
        child.x = nx;
        child.y = ny;
        child.b = r_item.b - step;
        child.f = step;
        origin.x = ox;
        origin.y = oy;
        origin.b = b0;
        origin.f = f0;
    end

    // memory address and data selection
    always_comb begin
        lvl_we     = i_cmd.clr_cells | i_cmd.deposit;
        col_we     = lvl_we;
        lvl_waddr  = i_cmd.clr_cells ? r_clr : cell_idx(r_item.x, r_item.y);
        lvl_wdata  = i_cmd.clr_cells ? 16'd0 : new_lv;
        col_wdata  = i_cmd.clr_cells ? 24'd0 : r_whue;
        cell_re    = i_cmd.qry_rd | i_cmd.item_ld;
        cell_raddr = i_cmd.item_ld ? cell_idx(q_rdata.x, q_rdata.y)
                                   : cell_idx(COORD_W'(r_in.pos_x[13:8]),
                                              COORD_W'(r_in.pos_y[13:8]));
        vis_we     = i_cmd.clr_cells | i_cmd.clr_visit | i_cmd.walk_init | i_cmd.nb_push;
        vis_wdata  = i_cmd.walk_init | i_cmd.nb_push;
        if (i_cmd.walk_init) vis_waddr = cell_idx(ox, oy);
        else if (i_cmd.nb_push) vis_waddr = cell_idx(nx, ny);
        else vis_waddr = r_clr;
        vis_re     = i_cmd.nb_rd;
        vis_raddr  = cell_idx(nx, ny);
        q_we       = i_cmd.walk_init | i_cmd.nb_push;
        q_waddr    = i_cmd.walk_init ? '0 : r_tail[CW-1:0];
        q_wdata    = i_cmd.walk_init ? origin : child;
        tbl_wdata.id  = r_next_id;
        tbl_wdata.px  = r_in.pos_x;
        tbl_wdata.py  = r_in.pos_y;
        tbl_wdata.b   = r_in.brightness;
        tbl_wdata.f   = r_in.falloff;
        tbl_wdata.hue = {r_in.hue_red, r_in.hue_green, r_in.hue_blue};
    end

    tlfm_ram #(.WIDTH(16), .DEPTH(CELLS)) u_level (
        .i_clk(i_clk), .i_we(lvl_we), .i_waddr(lvl_waddr), .i_wdata(lvl_wdata),
        .i_re(cell_re), .i_raddr(cell_raddr), .o_rdata(lvl_rdata)
    );

    tlfm_ram #(.WIDTH(24), .DEPTH(CELLS)) u_colour (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(lvl_waddr), .i_wdata(col_wdata),
        .i_re(cell_re), .i_raddr(cell_raddr), .o_rdata(col_rdata)
    );

    tlfm_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_waddr), .i_wdata(vis_wdata),
        .i_re(vis_re), .i_raddr(vis_raddr), .o_rdata(vis_rdata)
    );

    tlfm_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_re(i_cmd.q_rd), .i_raddr(r_head[CW-1:0]), .o_rdata(q_rdata)
    );

    tlfm_ram #(.WIDTH(LW), .DEPTH(MAX_LIGHTS)) u_table (
        .i_clk(i_clk), .i_we(i_cmd.tbl_wr), .i_waddr(r_slot), .i_wdata(tbl_wdata),
        .i_re(i_cmd.tbl_rd), .i_raddr(r_slot), .o_rdata(tbl_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_slot      <= '0;
            r_valid     <= '0;
            r_next_id   <= '0;
            r_dk        <= '0;
            r_nb        <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_rst) r_clr <= '0;
            else if (i_cmd.clr_inc) r_clr <= r_clr + 1'b1;
            if (i_cmd.slot_rst) r_slot <= '0;
            else if (i_cmd.slot_inc) r_slot <= r_slot + 1'b1;
            if (i_cmd.valid_set) r_valid[r_slot] <= 1'b1;
            if (i_cmd.valid_clr) r_valid[r_slot] <= 1'b0;
            if (i_cmd.tbl_wr) r_next_id <= r_next_id + 16'd1;
            if (i_cmd.dir_rst) r_dk <= '0;
            else if (i_cmd.dir_step) r_dk <= r_dk + 1'b1;
            if (i_cmd.nb_rst) r_nb <= '0;
            else if (i_cmd.nb_inc) r_nb <= r_nb + 1'b1;
            if (i_cmd.walk_init) begin
                r_head <= '0;
                r_tail <= TW'(1);
            end else begin
                if (i_cmd.head_inc) r_head <= r_head + 1'b1;
                if (i_cmd.nb_push) r_tail <= r_tail + 1'b1;
            end
            if (i_cmd.res_ld) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) r_in <= i_in_data;
        if (i_cmd.tbl_wr) r_new_id <= r_next_id;
        if (i_cmd.ld_src_in) begin
            r_wpx  <= r_in.pos_x;
            r_wpy  <= r_in.pos_y;
            r_wb   <= r_in.brightness;
            r_wf   <= r_in.falloff;
            r_whue <= {r_in.hue_red, r_in.hue_green, r_in.hue_blue};
            r_wneg <= 1'b0;
        end else if (i_cmd.ld_src_tbl) begin
            r_wpx  <= tbl_rdata.px;
            r_wpy  <= tbl_rdata.py;
            r_wb   <= tbl_rdata.b;
            r_wf   <= tbl_rdata.f;
            r_whue <= tbl_rdata.hue;
            r_wneg <= 1'b1;
        end
        if (i_cmd.dir_step) begin
            r_dir[r_dk] <= r_wneg ? -$signed({1'b0, dprod[24:8]})
                                  : $signed({1'b0, dprod[24:8]});
        end
        if (i_cmd.item_ld) r_item <= q_rdata;
        if (i_cmd.qry_mul) begin
            r_q_big <= (lvl_rdata > 16'd255);
            r_q_lv  <= lvl_rdata[7:0];
            r_qp_r  <= col_rdata[23:16] * lvl_rdata[7:0];
            r_qp_g  <= col_rdata[15:8] * lvl_rdata[7:0];
            r_qp_b  <= col_rdata[7:0] * lvl_rdata[7:0];
        end
        if (i_cmd.res_ld) begin
            r_out        <= '0;
            r_out.status <= i_cmd.res_status;
            if (i_cmd.res_sel == RES_ADD) r_out.new_id <= r_new_id;
            if (i_cmd.res_sel == RES_QUERY) begin
                r_out.level     <= r_q_big ? 8'd255 : r_q_lv;
                r_out.out_red   <= r_q_big ? 8'd0 : div255(r_qp_r);
                r_out.out_green <= r_q_big ? 8'd0 : div255(r_qp_g);
                r_out.out_blue  <= r_q_big ? 8'd0 : div255(r_qp_b);
            end
        end
    end

    // status to the controller
    always_comb begin
        o_stat.op        = r_in.opcode;
        o_stat.origin_on = (9'(r_in.pos_x[13:8]) < uw) && (9'(r_in.pos_y[13:8]) < ud);
        o_stat.place_on  = (9'(tbl_rdata.px[13:8]) < uw) && (9'(tbl_rdata.py[13:8]) < ud);
        o_stat.clr_last  = (r_clr == CW'(CELLS - 1));
        o_stat.slot_last = (r_slot == SW'(MAX_LIGHTS - 1));
        o_stat.slot_free = !r_valid[r_slot];
        o_stat.id_match  = r_valid[r_slot] && (tbl_rdata.id == r_in.light_id);
        o_stat.dir_last  = (r_dk == 2'(DIR_UP));
        o_stat.spread    = mag(r_item.b) > mag(r_item.f);
        o_stat.nb_last   = (r_nb == 2'(DIR_UP));
        o_stat.nb_free   = nb_ok && !vis_rdata;
        o_stat.walk_last = ((r_head + 1'b1) == r_tail);
        o_stat.out_busy  = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_ld |-> !r_out_valid)
        else $error("result loaded over a pending item");
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("walk head passed tail");
    a_tail_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= TW'(CELLS))
        else $error("walk queue overflow");
    a_slot_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid_set |-> !r_valid[r_slot])
        else $error("light slot taken twice");
`endif

endmodule
